// ===== rtl/segment_box_intersect_test_assert.svh =====
// Assertion macros for the segment and box intersection test.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SEGMENT_BOX_INTERSECT_TEST_ASSERT_SVH
`define SEGMENT_BOX_INTERSECT_TEST_ASSERT_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define SBIT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define SBIT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define SBIT_ASSERT_SAME(label, ante, cons)
`define SBIT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/sbit_pkg.sv =====
package sbit_pkg;

  // Configuration register indexes.
  typedef logic [1:0] reg_index_t;
  localparam reg_index_t REG_BOX_X_LOW  = 2'd0;
  localparam reg_index_t REG_BOX_X_HIGH = 2'd1;
  localparam reg_index_t REG_BOX_Y_LOW  = 2'd2;
  localparam reg_index_t REG_BOX_Y_HIGH = 2'd3;

  // Box edges, in the order they are tested.
  localparam int NUM_EDGES = 4;
  typedef logic [1:0] edge_t;
  localparam edge_t EDGE_BOTTOM = 2'd0;
  localparam edge_t EDGE_RIGHT  = 2'd1;
  localparam edge_t EDGE_LEFT   = 2'd2;
  localparam edge_t EDGE_TOP    = 2'd3;

  // Per-item verdicts handed from the ratio stage to the output stage.
  typedef struct packed {
    logic                 in_box;
    logic [NUM_EDGES-1:0] s_ok;
    logic [NUM_EDGES-1:0] t_ok;
  } flags_t;

endpackage

// ===== rtl/sbit_diff.sv =====
module sbit_diff #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH-1:0] seg_start_x,
  input  logic signed [COORD_WIDTH-1:0] seg_start_y,
  input  logic signed [COORD_WIDTH-1:0] seg_end_x,
  input  logic signed [COORD_WIDTH-1:0] seg_end_y,
  input  logic signed [COORD_WIDTH-1:0] box_x_low,
  input  logic signed [COORD_WIDTH-1:0] box_x_high,
  input  logic signed [COORD_WIDTH-1:0] box_y_low,
  input  logic signed [COORD_WIDTH-1:0] box_y_high,
  output logic signed [COORD_WIDTH:0]   s1x,
  output logic signed [COORD_WIDTH:0]   s1y,
  output logic signed [COORD_WIDTH:0]   wx,
  output logic signed [COORD_WIDTH:0]   hy,
  output logic signed [COORD_WIDTH:0]   dxl,
  output logic signed [COORD_WIDTH:0]   dxh,
  output logic signed [COORD_WIDTH:0]   dyl,
  output logic signed [COORD_WIDTH:0]   dyh,
  output logic                          in_box
);

  localparam int DW = COORD_WIDTH + 1;

  // Segment direction, box extents and start point offsets from the box edges.
  always_ff @(posedge clk) begin
    if (en) begin
      s1x    <= DW'(seg_end_x) - DW'(seg_start_x);
      s1y    <= DW'(seg_end_y) - DW'(seg_start_y);
      wx     <= DW'(box_x_high) - DW'(box_x_low);
      hy     <= DW'(box_y_high) - DW'(box_y_low);
      dxl    <= DW'(seg_start_x) - DW'(box_x_low);
      dxh    <= DW'(seg_start_x) - DW'(box_x_high);
      dyl    <= DW'(seg_start_y) - DW'(box_y_low);
      dyh    <= DW'(seg_start_y) - DW'(box_y_high);
      in_box <= (box_x_low <= seg_start_x) && (seg_start_x <= box_x_high) &&
                (box_y_low <= seg_start_y) && (seg_start_y <= box_y_high);
    end
  end

endmodule

// ===== rtl/sbit_mul.sv =====
module sbit_mul #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [COORD_WIDTH:0]       s1x,
  input  logic signed [COORD_WIDTH:0]       s1y,
  input  logic signed [COORD_WIDTH:0]       wx,
  input  logic signed [COORD_WIDTH:0]       hy,
  input  logic signed [COORD_WIDTH:0]       dxl,
  input  logic signed [COORD_WIDTH:0]       dxh,
  input  logic signed [COORD_WIDTH:0]       dyl,
  input  logic signed [COORD_WIDTH:0]       dyh,
  input  logic                              inside_in,
  output logic signed [2*COORD_WIDTH+1:0]   p_den_h,
  output logic signed [2*COORD_WIDTH+1:0]   p_den_v,
  output logic signed [2*COORD_WIDTH+1:0]   p_tb,
  output logic signed [2*COORD_WIDTH+1:0]   p_tt,
  output logic signed [2*COORD_WIDTH+1:0]   p_tr,
  output logic signed [2*COORD_WIDTH+1:0]   p_tl,
  output logic signed [2*COORD_WIDTH+1:0]   p_a,
  output logic signed [2*COORD_WIDTH+1:0]   p_b,
  output logic signed [2*COORD_WIDTH+1:0]   p_c,
  output logic signed [2*COORD_WIDTH+1:0]   p_d,
  output logic                              in_box
);

  localparam int PW = 2 * COORD_WIDTH + 2;

  // Ten exact signed products; the edges are axis aligned, so each cross
  // product of the general test collapses to one or two of these.
  always_ff @(posedge clk) begin
    if (en) begin
      p_den_h <= PW'(wx) * PW'(s1y);
      p_den_v <= PW'(s1x) * PW'(hy);
      p_tb    <= PW'(wx) * PW'(dyl);
      p_tt    <= PW'(wx) * PW'(dyh);
      p_tr    <= PW'(hy) * PW'(dxh);
      p_tl    <= PW'(hy) * PW'(dxl);
      p_a     <= PW'(s1x) * PW'(dyl);
      p_b     <= PW'(s1y) * PW'(dxl);
      p_c     <= PW'(s1y) * PW'(dxh);
      p_d     <= PW'(s1x) * PW'(dyh);
      in_box  <= inside_in;
    end
  end

endmodule

// ===== rtl/sbit_sum.sv =====
module sbit_sum #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [2*COORD_WIDTH+1:0]   p_den_h,
  input  logic signed [2*COORD_WIDTH+1:0]   p_den_v,
  input  logic signed [2*COORD_WIDTH+1:0]   p_tb,
  input  logic signed [2*COORD_WIDTH+1:0]   p_tt,
  input  logic signed [2*COORD_WIDTH+1:0]   p_tr,
  input  logic signed [2*COORD_WIDTH+1:0]   p_tl,
  input  logic signed [2*COORD_WIDTH+1:0]   p_a,
  input  logic signed [2*COORD_WIDTH+1:0]   p_b,
  input  logic signed [2*COORD_WIDTH+1:0]   p_c,
  input  logic signed [2*COORD_WIDTH+1:0]   p_d,
  input  logic                              inside_in,
  output logic signed [2*COORD_WIDTH+2:0]   den_h,
  output logic signed [2*COORD_WIDTH+2:0]   den_v,
  output logic signed [2*COORD_WIDTH+2:0]   sn_bl,
  output logic signed [2*COORD_WIDTH+2:0]   sn_r,
  output logic signed [2*COORD_WIDTH+2:0]   sn_t,
  output logic signed [2*COORD_WIDTH+2:0]   tn_b,
  output logic signed [2*COORD_WIDTH+2:0]   tn_r,
  output logic signed [2*COORD_WIDTH+2:0]   tn_l,
  output logic signed [2*COORD_WIDTH+2:0]   tn_t,
  output logic                              in_box
);

  localparam int SW = 2 * COORD_WIDTH + 3;

  // Denominators and numerators of the bottom, right, left and top edge
  // tests. Horizontal edges share a denominator, vertical edges the other, and
  // bottom and left share the segment numerator; both start at the low corner.
  always_ff @(posedge clk) begin
    if (en) begin
      den_h  <= -SW'(p_den_h);
      den_v  <= SW'(p_den_v);
      sn_bl  <= SW'(p_a) - SW'(p_b);
      sn_r   <= SW'(p_a) - SW'(p_c);
      sn_t   <= SW'(p_d) - SW'(p_b);
      tn_b   <= SW'(p_tb);
      tn_t   <= SW'(p_tt);
      tn_r   <= -SW'(p_tr);
      tn_l   <= -SW'(p_tl);
      in_box <= inside_in;
    end
  end

endmodule

// ===== rtl/sbit_ratio.sv =====
module sbit_ratio #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [2*COORD_WIDTH+2:0]   den_h,
  input  logic signed [2*COORD_WIDTH+2:0]   den_v,
  input  logic signed [2*COORD_WIDTH+2:0]   sn_bl,
  input  logic signed [2*COORD_WIDTH+2:0]   sn_r,
  input  logic signed [2*COORD_WIDTH+2:0]   sn_t,
  input  logic signed [2*COORD_WIDTH+2:0]   tn_b,
  input  logic signed [2*COORD_WIDTH+2:0]   tn_r,
  input  logic signed [2*COORD_WIDTH+2:0]   tn_l,
  input  logic signed [2*COORD_WIDTH+2:0]   tn_t,
  input  logic                              inside_in,
  output sbit_pkg::flags_t                  flags
);

  import sbit_pkg::*;

  localparam int SW = 2 * COORD_WIDTH + 3;

  flags_t flags_next;

  // True when den is nonzero and num/den lies in [0,1]. For a negative
  // denominator the bounds flip instead of negating both values.
  function automatic logic in_unit(input logic signed [SW-1:0] num,
                                   input logic signed [SW-1:0] den);
    logic den_zero;
    logic den_neg;
    den_zero = (den == '0);
    den_neg  = den[SW-1];
    if (den_zero) begin
      in_unit = 1'b0;
    end else if (den_neg) begin
      in_unit = (num <= 0) && (num >= den);
    end else begin
      in_unit = (num >= 0) && (num <= den);
    end
  endfunction

  // Range check of every numerator against its edge's denominator.
  always_comb begin
    flags_next.in_box             = inside_in;
    flags_next.s_ok[EDGE_BOTTOM]  = in_unit(sn_bl, den_h);
    flags_next.t_ok[EDGE_BOTTOM]  = in_unit(tn_b, den_h);
    flags_next.s_ok[EDGE_RIGHT]   = in_unit(sn_r, den_v);
    flags_next.t_ok[EDGE_RIGHT]   = in_unit(tn_r, den_v);
    flags_next.s_ok[EDGE_LEFT]    = in_unit(sn_bl, den_v);
    flags_next.t_ok[EDGE_LEFT]    = in_unit(tn_l, den_v);
    flags_next.s_ok[EDGE_TOP]     = in_unit(sn_t, den_h);
    flags_next.t_ok[EDGE_TOP]     = in_unit(tn_t, den_h);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags <= flags_next;
    end
  end

endmodule

// ===== rtl/segment_box_intersect_test.sv =====
// Segment against box intersection test.
// The box is set through the write port (cfg_en, cfg_index, cfg_data): index 0
// to 3 select the left, right, bottom and top edge. Write it only while no
// item is in flight. Each item on the input channel is one segment given by
// its start and end point; each produces exactly one result item on the
// output channel, hit, set when the start point is in or on the box or the
// segment crosses one of the box edges.
// Items move through four register stages (differences, products, sums,
// range checks) and an output register, in that order. One item can be
// accepted in every cycle in which in_stall is low.
// When out_stall is high the output register holds its item; the stages
// behind it keep filling any empty slot, so in_stall rises only once every
// stage holds an item. Reset clears the box registers to zero and empties
// the pipeline; the block accepts items as soon as reset is released.
`include "segment_box_intersect_test_assert.svh"

module segment_box_intersect_test #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_en,
  input  sbit_pkg::reg_index_t          cfg_index,
  input  logic        [COORD_WIDTH-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] seg_start_x,
  input  logic signed [COORD_WIDTH-1:0] seg_start_y,
  input  logic signed [COORD_WIDTH-1:0] seg_end_x,
  input  logic signed [COORD_WIDTH-1:0] seg_end_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit
);

  import sbit_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * COORD_WIDTH + 2;
  localparam int SW = 2 * COORD_WIDTH + 3;

  logic signed [COORD_WIDTH-1:0] box_x_low;
  logic signed [COORD_WIDTH-1:0] box_x_high;
  logic signed [COORD_WIDTH-1:0] box_y_low;
  logic signed [COORD_WIDTH-1:0] box_y_high;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en_out;

  logic signed [DW-1:0] s1x, s1y, wx, hy, dxl, dxh, dyl, dyh;
  logic                 inside1, inside2, inside3;
  logic signed [PW-1:0] p_den_h, p_den_v, p_tb, p_tt, p_tr, p_tl;
  logic signed [PW-1:0] p_a, p_b, p_c, p_d;
  logic signed [SW-1:0] den_h, den_v, sn_bl, sn_r, sn_t;
  logic signed [SW-1:0] tn_b, tn_r, tn_l, tn_t;
  flags_t               flags;

  // Box registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      box_x_low  <= '0;
      box_x_high <= '0;
      box_y_low  <= '0;
      box_y_high <= '0;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_BOX_X_LOW:  box_x_low  <= cfg_data;
        REG_BOX_X_HIGH: box_x_high <= cfg_data;
        REG_BOX_Y_LOW:  box_y_low  <= cfg_data;
        REG_BOX_Y_HIGH: box_y_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its item moves on in the same cycle.
  always_comb begin
    en_out   = !out_valid || !out_stall;
    en4      = !v4 || en_out;
    en3      = !v3 || en4;
    en2      = !v2 || en3;
    en1      = !v1 || en2;
    in_stall = !en1;
  end

  // Valid bits travel with the items.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1)    v1        <= in_valid;
      if (en2)    v2        <= v1;
      if (en3)    v3        <= v2;
      if (en4)    v4        <= v3;
      if (en_out) out_valid <= v4;
    end
  end

  sbit_diff #(.COORD_WIDTH(COORD_WIDTH)) u_diff (
    .clk         (clk),
    .en          (en1),
    .seg_start_x (seg_start_x),
    .seg_start_y (seg_start_y),
    .seg_end_x   (seg_end_x),
    .seg_end_y   (seg_end_y),
    .box_x_low   (box_x_low),
    .box_x_high  (box_x_high),
    .box_y_low   (box_y_low),
    .box_y_high  (box_y_high),
    .s1x         (s1x),
    .s1y         (s1y),
    .wx          (wx),
    .hy          (hy),
    .dxl         (dxl),
    .dxh         (dxh),
    .dyl         (dyl),
    .dyh         (dyh),
    .in_box      (inside1)
  );

  sbit_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul (
    .clk       (clk),
    .en        (en2),
    .s1x       (s1x),
    .s1y       (s1y),
    .wx        (wx),
    .hy        (hy),
    .dxl       (dxl),
    .dxh       (dxh),
    .dyl       (dyl),
    .dyh       (dyh),
    .inside_in (inside1),
    .p_den_h   (p_den_h),
    .p_den_v   (p_den_v),
    .p_tb      (p_tb),
    .p_tt      (p_tt),
    .p_tr      (p_tr),
    .p_tl      (p_tl),
    .p_a       (p_a),
    .p_b       (p_b),
    .p_c       (p_c),
    .p_d       (p_d),
    .in_box    (inside2)
  );

  sbit_sum #(.COORD_WIDTH(COORD_WIDTH)) u_sum (
    .clk       (clk),
    .en        (en3),
    .p_den_h   (p_den_h),
    .p_den_v   (p_den_v),
    .p_tb      (p_tb),
    .p_tt      (p_tt),
    .p_tr      (p_tr),
    .p_tl      (p_tl),
    .p_a       (p_a),
    .p_b       (p_b),
    .p_c       (p_c),
    .p_d       (p_d),
    .inside_in (inside2),
    .den_h     (den_h),
    .den_v     (den_v),
    .sn_bl     (sn_bl),
    .sn_r      (sn_r),
    .sn_t      (sn_t),
    .tn_b      (tn_b),
    .tn_r      (tn_r),
    .tn_l      (tn_l),
    .tn_t      (tn_t),
    .in_box    (inside3)
  );

  sbit_ratio #(.COORD_WIDTH(COORD_WIDTH)) u_ratio (
    .clk       (clk),
    .en        (en4),
    .den_h     (den_h),
    .den_v     (den_v),
    .sn_bl     (sn_bl),
    .sn_r      (sn_r),
    .sn_t      (sn_t),
    .tn_b      (tn_b),
    .tn_r      (tn_r),
    .tn_l      (tn_l),
    .tn_t      (tn_t),
    .inside_in (inside3),
    .flags     (flags)
  );

  // Output register: a hit is the start point test or a crossing on any edge.
  always_ff @(posedge clk) begin
    if (en_out) begin
      hit <= flags.in_box || (|(flags.s_ok & flags.t_ok));
    end
  end

  // An accepted item always lands in the first stage.
  `SBIT_ASSERT_NEXT(a_accept_fills, in_valid && !in_stall, v1)
  // A result cannot appear unless the last stage held an item.
  `SBIT_ASSERT_NEXT(a_no_phantom, !v4 && !out_valid, !out_valid)
  // An empty pipeline never stalls its input.
  `SBIT_ASSERT_SAME(a_idle_ready, !v1 && !v2 && !v3 && !v4 && !out_valid, !in_stall)

endmodule
